>>> src/htd_pkg.sv
// shared types and constants for the huffman tree decoder
package htd_pkg;

  localparam int SYMBOL_W   = 8;
  localparam int CODE_LEN_W = 6;
  localparam int CODE_W     = 32;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DECODE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_MISSING  = 2'd2;
  localparam logic [1:0] STAT_ZERO_LEN = 2'd3;

  typedef struct packed {
    logic [1:0]            command;
    logic [SYMBOL_W-1:0]   symbol;
    logic [CODE_LEN_W-1:0] code_length;
    logic [CODE_W-1:0]     code_bits;
    logic                  data_bit;
  } item_t;

  typedef struct packed {
    logic                symbol_valid;
    logic [SYMBOL_W-1:0] decoded_symbol;
    logic [1:0]          status;
  } result_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctrl_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ADD_RD,
    S_ADD_STEP,
    S_ADD_NEW,
    S_ADD_LEAF,
    S_DEC_CHILD,
    S_DEC_LEAF,
    S_DONE
  } state_t;

endpackage

>>> src/htd_node_mem.sv
// single-port node table with registered read data
module htd_node_mem #(
  parameter int DEPTH  = 512,
  parameter int DATA_W = 27
) (
  input  logic                     clk,
  input  htd_pkg::mem_ctrl_t       ctrl,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wr_data,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

>>> src/htd_walker.sv
// sequencer that walks the code tree for add, decode and clear commands
module htd_walker #(
  parameter int NODE_DEPTH   = 512,
  parameter int MAX_CODE_LEN = 32,
  localparam int IDX_W       = $clog2(NODE_DEPTH),
  localparam int NODE_W      = 2 * IDX_W + htd_pkg::SYMBOL_W + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  htd_pkg::item_t     item,
  output logic               idle,
  output logic               res_valid,
  input  logic               res_ready,
  output htd_pkg::result_t   res,
  output htd_pkg::mem_ctrl_t mem_ctrl,
  output logic [IDX_W-1:0]   mem_addr,
  output logic [NODE_W-1:0]  mem_wr_data,
  input  logic [NODE_W-1:0]  mem_rd_data
);

  localparam int CNT_W = $clog2(NODE_DEPTH + 1);
  localparam int SW    = htd_pkg::SYMBOL_W;
  localparam int LW    = htd_pkg::CODE_LEN_W;

  htd_pkg::state_t state, state_next;

  logic [CNT_W-1:0]          node_count;
  logic [IDX_W-1:0]          cursor;
  logic [IDX_W-1:0]          cur;
  logic [IDX_W-1:0]          nxt;
  logic [NODE_W-1:0]         cur_node;
  logic [htd_pkg::CODE_W-1:0] code_sh;
  logic [LW-1:0]             remaining;
  logic [SW-1:0]             sym;
  logic                      dbit;

  logic [LW-1:0]    eff_len;
  logic [IDX_W-1:0] cur_one, cur_zero, slot;
  logic [IDX_W-1:0] rd_one, rd_zero, rd_sel;
  logic             rd_leaf;
  logic             full;
  logic [IDX_W-1:0] new_idx;

  assign eff_len = ({1'b0, item.code_length} > (LW + 1)'(MAX_CODE_LEN)) ?
                   LW'(MAX_CODE_LEN) : item.code_length;

  assign cur_one  = cur_node[NODE_W-1 -: IDX_W];
  assign cur_zero = cur_node[IDX_W+SW -: IDX_W];
  assign slot     = code_sh[0] ? cur_one : cur_zero;

  assign rd_one  = mem_rd_data[NODE_W-1 -: IDX_W];
  assign rd_zero = mem_rd_data[IDX_W+SW -: IDX_W];
  assign rd_leaf = mem_rd_data[SW];
  assign rd_sel  = dbit ? rd_one : rd_zero;

  assign full    = (node_count >= CNT_W'(NODE_DEPTH));
  assign new_idx = node_count[IDX_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      htd_pkg::S_INIT: state_next = htd_pkg::S_IDLE;
      htd_pkg::S_IDLE: begin
        if (item_valid) begin
          case (item.command)
            htd_pkg::CMD_ADD:
              state_next = (item.code_length == '0) ? htd_pkg::S_DONE : htd_pkg::S_ADD_RD;
            htd_pkg::CMD_DECODE: state_next = htd_pkg::S_DEC_CHILD;
            default: state_next = htd_pkg::S_DONE;
          endcase
        end
      end
      htd_pkg::S_ADD_RD:
        state_next = (remaining == '0) ? htd_pkg::S_ADD_LEAF : htd_pkg::S_ADD_STEP;
      htd_pkg::S_ADD_STEP: begin
        if (slot != '0) begin
          state_next = htd_pkg::S_ADD_RD;
        end else if (full) begin
          state_next = htd_pkg::S_DONE;
        end else begin
          state_next = htd_pkg::S_ADD_NEW;
        end
      end
      htd_pkg::S_ADD_NEW:
        state_next = (remaining == '0) ? htd_pkg::S_ADD_LEAF : htd_pkg::S_ADD_STEP;
      htd_pkg::S_ADD_LEAF: state_next = htd_pkg::S_DONE;
      htd_pkg::S_DEC_CHILD:
        state_next = (rd_sel == '0) ? htd_pkg::S_DONE : htd_pkg::S_DEC_LEAF;
      htd_pkg::S_DEC_LEAF: state_next = htd_pkg::S_DONE;
      htd_pkg::S_DONE: begin
        if (res_ready) begin
          state_next = htd_pkg::S_IDLE;
        end
      end
      default: state_next = htd_pkg::S_INIT;
    endcase
  end

  // outputs and node table port
  always_comb begin
    idle        = 1'b0;
    res_valid   = 1'b0;
    mem_ctrl    = '0;
    mem_addr    = '0;
    mem_wr_data = '0;
    unique case (state)
      htd_pkg::S_INIT: begin
        mem_ctrl.wr_en = 1'b1;
      end
      htd_pkg::S_IDLE: begin
        idle = 1'b1;
        if (item_valid) begin
          case (item.command)
            htd_pkg::CMD_ADD: mem_ctrl.rd_en = (item.code_length != '0);
            htd_pkg::CMD_DECODE: begin
              mem_ctrl.rd_en = 1'b1;
              mem_addr       = cursor;
            end
            htd_pkg::CMD_CLEAR: mem_ctrl.wr_en = 1'b1;
            default: ;
          endcase
        end
      end
      htd_pkg::S_ADD_RD: ;
      htd_pkg::S_ADD_STEP: begin
        if (slot != '0) begin
          mem_ctrl.rd_en = 1'b1;
          mem_addr       = slot;
        end else if (!full) begin
          mem_ctrl.wr_en = 1'b1;
          mem_addr       = cur;
          mem_wr_data    = code_sh[0] ? {new_idx, cur_zero, cur_node[SW:0]}
                                      : {cur_one, new_idx, cur_node[SW:0]};
        end
      end
      htd_pkg::S_ADD_NEW: begin
        mem_ctrl.wr_en = 1'b1;
        mem_addr       = cur;
      end
      htd_pkg::S_ADD_LEAF: begin
        mem_ctrl.wr_en = 1'b1;
        mem_addr       = cur;
        mem_wr_data    = {cur_one, cur_zero, 1'b1, sym};
      end
      htd_pkg::S_DEC_CHILD: begin
        if (rd_sel != '0) begin
          mem_ctrl.rd_en = 1'b1;
          mem_addr       = rd_sel;
        end
      end
      htd_pkg::S_DEC_LEAF: ;
      htd_pkg::S_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= htd_pkg::S_INIT;
      node_count <= CNT_W'(1);
      cursor     <= '0;
    end else begin
      state <= state_next;
      case (state)
        htd_pkg::S_IDLE: begin
          if (item_valid && item.command == htd_pkg::CMD_CLEAR) begin
            node_count <= CNT_W'(1);
            cursor     <= '0;
          end
        end
        htd_pkg::S_ADD_STEP: begin
          if (slot == '0 && !full) begin
            node_count <= node_count + CNT_W'(1);
          end
        end
        htd_pkg::S_DEC_CHILD: begin
          if (rd_sel == '0) begin
            cursor <= '0;
          end
        end
        htd_pkg::S_DEC_LEAF: cursor <= rd_leaf ? '0 : nxt;
        default: ;
      endcase
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    case (state)
      htd_pkg::S_IDLE: begin
        if (item_valid) begin
          sym       <= item.symbol;
          code_sh   <= item.code_bits;
          remaining <= eff_len;
          dbit      <= item.data_bit;
          cur       <= '0;
          res.symbol_valid   <= 1'b0;
          res.decoded_symbol <= '0;
          res.status <= (item.command == htd_pkg::CMD_ADD && item.code_length == '0) ?
                        htd_pkg::STAT_ZERO_LEN : htd_pkg::STAT_OK;
        end
      end
      htd_pkg::S_ADD_RD: cur_node <= mem_rd_data;
      htd_pkg::S_ADD_STEP: begin
        if (slot != '0) begin
          cur       <= slot;
          code_sh   <= code_sh >> 1;
          remaining <= remaining - LW'(1);
        end else if (full) begin
          res.status <= htd_pkg::STAT_FULL;
        end else begin
          cur       <= new_idx;
          cur_node  <= '0;
          code_sh   <= code_sh >> 1;
          remaining <= remaining - LW'(1);
        end
      end
      htd_pkg::S_DEC_CHILD: begin
        nxt <= rd_sel;
        if (rd_sel == '0) begin
          res.status <= htd_pkg::STAT_MISSING;
        end
      end
      htd_pkg::S_DEC_LEAF: begin
        if (rd_leaf) begin
          res.symbol_valid   <= 1'b1;
          res.decoded_symbol <= mem_rd_data[SW-1:0];
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    node_count >= CNT_W'(1) && node_count <= CNT_W'(NODE_DEPTH))
    else $error("node count out of range");

  a_single_port: assert property (@(posedge clk) disable iff (rst)
    !(mem_ctrl.rd_en && mem_ctrl.wr_en))
    else $error("read and write in one cycle");

  a_cursor_alloc: assert property (@(posedge clk) disable iff (rst)
    state == htd_pkg::S_IDLE |-> CNT_W'(cursor) < node_count)
    else $error("cursor points past allocated nodes");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    state == htd_pkg::S_IDLE && item_valid |=> state != htd_pkg::S_IDLE)
    else $error("sequencer stayed idle after a transfer");
`endif

endmodule

>>> src/huffman_tree_decoder.sv
// Huffman tree decoder: one command per transfer, one result per command.
// Nodes live in a single-port table of NODE_DEPTH entries, and every
// command is worked through at most one table access per cycle. A decode
// bit goes from transfer to result through read node, read child, check
// leaf and hand-off; the child read and the leaf check are skipped when
// the branch is missing. An add entry walks its code bit by bit (length
// saturated to MAX_CODE_LEN) and stops early when the table fills during
// the walk; a zero-length add, a clear or an unknown command goes straight
// to the result. After reset the root is written before the first
// transfer. A new command is taken only once the previous result has
// moved into the output register; that register lets the next command
// start while the result waits on a stall.
module huffman_tree_decoder #(
  parameter int NODE_DEPTH   = 512,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  htd_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output htd_pkg::result_t result
);

  localparam int IDX_W  = $clog2(NODE_DEPTH);
  localparam int NODE_W = 2 * IDX_W + htd_pkg::SYMBOL_W + 1;

  logic               idle;
  logic               res_valid;
  logic               res_ready;
  htd_pkg::result_t   res;
  htd_pkg::mem_ctrl_t mem_ctrl;
  logic [IDX_W-1:0]   mem_addr;
  logic [NODE_W-1:0]  mem_wr_data;
  logic [NODE_W-1:0]  mem_rd_data;

  assign item_stall = !idle;
  assign res_ready  = !result_valid || !result_stall;

  htd_walker #(
    .NODE_DEPTH   (NODE_DEPTH),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_walker (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item        (item),
    .idle        (idle),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_ctrl    (mem_ctrl),
    .mem_addr    (mem_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_data (mem_rd_data)
  );

  htd_node_mem #(
    .DEPTH  (NODE_DEPTH),
    .DATA_W (NODE_W)
  ) u_node_mem (
    .clk     (clk),
    .ctrl    (mem_ctrl),
    .addr    (mem_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_ready) begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      result <= res;
    end
  end

endmodule

>>> tb/tb_huffman_tree_decoder.sv
// testbench for the huffman tree decoder: directed command table, then random command streams
module tb_huffman_tree_decoder;
  import htd_pkg::*;

  localparam int TREE_DEPTH = 512;
  localparam int MAX_LEN = 32;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 400;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    item_t   it;
    bit      known;
    result_t want;
  } step_row_t;

  typedef struct {
    int          len;
    logic [31:0] bits;
  } dict_code_t;

  logic    clk = 1'b0;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  int unsigned child_one_tbl [TREE_DEPTH];
  int unsigned child_zero_tbl [TREE_DEPTH];
  bit          leaf_tbl [TREE_DEPTH];
  logic [7:0]  leaf_sym_tbl [TREE_DEPTH];
  int unsigned node_cnt;
  int unsigned walk_node;

  result_t    decoder_out_q[$];
  dict_code_t codes_q[$];
  step_row_t  steps[$];

  int snd_idle_pct;
  int rcv_stall_pct;
  bit hold_request;
  int item_count;
  int mismatch_cnt;
  int idle_cycles;

  huffman_tree_decoder #(
    .NODE_DEPTH(TREE_DEPTH),
    .MAX_CODE_LEN(MAX_LEN)
  ) uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always #4 clk = ~clk;

  function automatic void wipe_tree();
    for (int i = 0; i < TREE_DEPTH; i++) begin
      child_one_tbl[i] = 0;
      child_zero_tbl[i] = 0;
      leaf_tbl[i] = 1'b0;
      leaf_sym_tbl[i] = '0;
    end
    node_cnt = 1;
    walk_node = 0;
  endfunction

  function automatic result_t tree_step(input item_t it);
    result_t     r;
    int unsigned cur;
    int unsigned nxt;
    int          len;
    bit          stop;
    r = '0;
    r.status = STAT_OK;
    case (it.command)
      CMD_ADD: begin
        len = it.code_length;
        if (len == 0) begin
          r.status = STAT_ZERO_LEN;
        end else begin
          if (len > MAX_LEN) len = MAX_LEN;
          cur = 0;
          stop = 1'b0;
          for (int k = 0; k < len && !stop; k++) begin
            nxt = it.code_bits[k] ? child_one_tbl[cur] : child_zero_tbl[cur];
            if (nxt == 0) begin
              if (node_cnt >= TREE_DEPTH) begin
                r.status = STAT_FULL;
                stop = 1'b1;
              end else begin
                child_one_tbl[node_cnt] = 0;
                child_zero_tbl[node_cnt] = 0;
                leaf_tbl[node_cnt] = 1'b0;
                leaf_sym_tbl[node_cnt] = '0;
                if (it.code_bits[k]) child_one_tbl[cur] = node_cnt;
                else child_zero_tbl[cur] = node_cnt;
                nxt = node_cnt;
                node_cnt++;
              end
            end
            if (!stop) cur = nxt;
          end
          if (!stop) begin
            leaf_tbl[cur] = 1'b1;
            leaf_sym_tbl[cur] = it.symbol;
          end
        end
      end
      CMD_DECODE: begin
        nxt = it.data_bit ? child_one_tbl[walk_node] : child_zero_tbl[walk_node];
        if (nxt == 0) begin
          r.status = STAT_MISSING;
          walk_node = 0;
        end else if (leaf_tbl[nxt]) begin
          r.symbol_valid = 1'b1;
          r.decoded_symbol = leaf_sym_tbl[nxt];
          walk_node = 0;
        end else begin
          walk_node = nxt;
        end
      end
      CMD_CLEAR: wipe_tree();
      default: ;
    endcase
    return r;
  endfunction

  function automatic item_t mk_item(input logic [1:0] cmd, input logic [7:0] sym,
                                    input logic [5:0] len, input logic [31:0] bits,
                                    input logic dbit);
    item_t it;
    it.command = cmd;
    it.symbol = sym;
    it.code_length = len;
    it.code_bits = bits;
    it.data_bit = dbit;
    return it;
  endfunction

  function automatic result_t mk_res(input logic v, input logic [7:0] sym,
                                     input logic [1:0] st);
    result_t r;
    r.symbol_valid = v;
    r.decoded_symbol = sym;
    r.status = st;
    return r;
  endfunction

  function automatic item_t noise_item();
    return mk_item(2'($urandom), 8'($urandom), 6'($urandom), $urandom, 1'($urandom));
  endfunction

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatch_cnt++;
    $display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (decoder_out_q.size() == 0) begin
      flag_mismatch("unexpected result", 0, got);
      return;
    end
    want = decoder_out_q.pop_front();
    if (got.symbol_valid !== want.symbol_valid)
      flag_mismatch("symbol_valid", want.symbol_valid, got.symbol_valid);
    if (got.decoded_symbol !== want.decoded_symbol)
      flag_mismatch("decoded_symbol", want.decoded_symbol, got.decoded_symbol);
    if (got.status !== want.status)
      flag_mismatch("status", want.status, got.status);
  endtask

  task automatic send_cmd(input item_t it, input bit known, input result_t want);
    result_t model_out;
    while ($urandom_range(99) < snd_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    model_out = tree_step(it);
    decoder_out_q.push_back(known ? want : model_out);
    item_count++;
  endtask

  task automatic fill_tree(input int n);
    item_t it;
    for (int k = 0; k < n; k++) begin
      it = noise_item();
      it.command = CMD_ADD;
      it.code_length = 6'($urandom_range(32, 63));
      send_cmd(it, 1'b0, '0);
    end
  endtask

  task automatic random_burst();
    int         pick;
    int         n;
    item_t      it;
    dict_code_t dc;
    pick = $urandom_range(99);
    it = noise_item();
    if (pick < 35) begin
      it.command = CMD_ADD;
      if ($urandom_range(9) < 8) it.code_length = 6'($urandom_range(1, 6));
      else it.code_length = 6'($urandom_range(0, 63));
      dc.len = it.code_length;
      dc.bits = it.code_bits;
      codes_q.push_back(dc);
      if (codes_q.size() > 12) void'(codes_q.pop_front());
      send_cmd(it, 1'b0, '0);
    end else if (pick < 70 && codes_q.size() != 0) begin
      // replay a known code bit by bit
      dc = codes_q[$urandom_range(codes_q.size() - 1)];
      n = (dc.len > MAX_LEN) ? MAX_LEN : dc.len;
      for (int k = 0; k < n; k++) begin
        it = noise_item();
        it.command = CMD_DECODE;
        it.data_bit = dc.bits[k];
        send_cmd(it, 1'b0, '0);
      end
    end else if (pick < 90) begin
      it.command = CMD_DECODE;
      send_cmd(it, 1'b0, '0);
    end else if (pick < 93) begin
      it.command = CMD_CLEAR;
      send_cmd(it, 1'b0, '0);
    end else if (pick < 95) begin
      it.command = CMD_UNUSED;
      send_cmd(it, 1'b0, '0);
    end else if (pick < 97) begin
      fill_tree(20);
    end else begin
      it.command = CMD_ADD;
      it.code_length = '0;
      send_cmd(it, 1'b0, '0);
    end
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) check_result(result);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    idle_cycles = 0;
    item_count = 0;
    mismatch_cnt = 0;
    hold_request = 1'b0;
    snd_idle_pct = 36;
    rcv_stall_pct = 64;
    wipe_tree();

    steps.push_back('{mk_item(CMD_DECODE, 8'h00, 6'd0, 32'h0, 1'b0), 1'b1,
                      mk_res(1'b0, 8'h00, STAT_MISSING)});
    steps.push_back('{mk_item(CMD_DECODE, 8'hFF, 6'd63, 32'hFFFF_FFFF, 1'b1), 1'b1,
                      mk_res(1'b0, 8'h00, STAT_MISSING)});
    steps.push_back('{mk_item(CMD_ADD, 8'h11, 6'd0, 32'hFFFF_FFFF, 1'b1), 1'b1,
                      mk_res(1'b0, 8'h00, STAT_ZERO_LEN)});
    steps.push_back('{mk_item(CMD_ADD, 8'h00, 6'd1, 32'h0, 1'b0), 1'b1,
                      mk_res(1'b0, 8'h00, STAT_OK)});
    steps.push_back('{mk_item(CMD_ADD, 8'hFF, 6'd1, 32'h1, 1'b0), 1'b1,
                      mk_res(1'b0, 8'h00, STAT_OK)});
    steps.push_back('{mk_item(CMD_DECODE, 8'h00, 6'd0, 32'h0, 1'b0), 1'b1,
                      mk_res(1'b1, 8'h00, STAT_OK)});
    steps.push_back('{mk_item(CMD_DECODE, 8'h00, 6'd0, 32'h0, 1'b1), 1'b1,
                      mk_res(1'b1, 8'hFF, STAT_OK)});
    // long code through an existing leaf, then the same path saturated
    steps.push_back('{mk_item(CMD_ADD, 8'hA5, 6'd32, 32'hFFFF_FFFF, 1'b0), 1'b1,
                      mk_res(1'b0, 8'h00, STAT_OK)});
    steps.push_back('{mk_item(CMD_DECODE, 8'h00, 6'd0, 32'h0, 1'b1), 1'b1,
                      mk_res(1'b1, 8'hFF, STAT_OK)});
    steps.push_back('{mk_item(CMD_ADD, 8'h5A, 6'd63, 32'hFFFF_FFFF, 1'b0), 1'b1,
                      mk_res(1'b0, 8'h00, STAT_OK)});
    steps.push_back('{mk_item(CMD_ADD, 8'h3C, 6'd2, 32'h2, 1'b0), 1'b1,
                      mk_res(1'b0, 8'h00, STAT_OK)});
    steps.push_back('{mk_item(CMD_ADD, 8'hC3, 6'd1, 32'h1, 1'b0), 1'b1,
                      mk_res(1'b0, 8'h00, STAT_OK)});
    steps.push_back('{mk_item(CMD_DECODE, 8'h00, 6'd0, 32'h0, 1'b1), 1'b1,
                      mk_res(1'b1, 8'hC3, STAT_OK)});
    steps.push_back('{mk_item(CMD_DECODE, 8'h00, 6'd0, 32'h0, 1'b0), 1'b1,
                      mk_res(1'b1, 8'h00, STAT_OK)});
    steps.push_back('{mk_item(CMD_UNUSED, 8'hFF, 6'd63, 32'hFFFF_FFFF, 1'b1), 1'b1,
                      mk_res(1'b0, 8'h00, STAT_OK)});
    steps.push_back('{mk_item(CMD_CLEAR, 8'hFF, 6'd63, 32'hFFFF_FFFF, 1'b1), 1'b1,
                      mk_res(1'b0, 8'h00, STAT_OK)});
    steps.push_back('{mk_item(CMD_DECODE, 8'h00, 6'd0, 32'h0, 1'b1), 1'b1,
                      mk_res(1'b0, 8'h00, STAT_MISSING)});
    steps.push_back('{mk_item(CMD_ADD, 8'h77, 6'd3, 32'h5, 1'b0), 1'b0, '0});
    steps.push_back('{mk_item(CMD_DECODE, 8'h00, 6'd0, 32'h0, 1'b1), 1'b0, '0});
    steps.push_back('{mk_item(CMD_DECODE, 8'h00, 6'd0, 32'h0, 1'b1), 1'b0, '0});
    steps.push_back('{mk_item(CMD_DECODE, 8'h00, 6'd0, 32'h0, 1'b1), 1'b0, '0});
    steps.push_back('{mk_item(CMD_DECODE, 8'h00, 6'd0, 32'h0, 1'b0), 1'b0, '0});
    steps.push_back('{mk_item(CMD_DECODE, 8'h00, 6'd0, 32'h0, 1'b1), 1'b0, '0});
    steps.push_back('{mk_item(CMD_ADD, 8'h99, 6'd40, 32'h0, 1'b1), 1'b0, '0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[i]) send_cmd(steps[i].it, steps[i].known, steps[i].want);
    fill_tree(20);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          snd_idle_pct = 36;
          rcv_stall_pct = 64;
        end
        1: begin
          snd_idle_pct = 64;
          rcv_stall_pct = 36;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_stall_pct = 0;
          hold_request = 1'b1;
        end
      endcase
      while (item_count < (ph + 1) * PHASE_ITEMS + steps.size() + 20) random_burst();
      // let every pending result drain
      item_valid <= 1'b0;
      do @(posedge clk); while (decoder_out_q.size() != 0);
    end

    repeat (8) @(posedge clk);
    if (decoder_out_q.size() != 0) flag_mismatch("missing results", 0, decoder_out_q.size());
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
